### hdl/pn2d_pkg.sv
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared types, widths and arithmetic helpers of the 2D gradient noise core.
// ----------------------------------------------------------------------------
package pn2d_pkg;

   // Input and output formats
   localparam int FRAC_BITS  = 16;                  // fraction bits of Q16.16
   localparam int COORD_W    = 32;
   localparam int ENTRY_W    = 8;
   localparam int TABLE_SIZE = 256;
   localparam int TABLE_BITS = $clog2(TABLE_SIZE);
   localparam int OUT_W      = 19;                  // Q2.16 result
   localparam int OUT_LIMIT  = 131072;

   // Fade polynomial coefficients: 6t^5 - 15t^4 + 10t^3
   localparam int FADE_A = 6;
   localparam int FADE_B = 15;
   localparam int FADE_C = 10;

   // Internal widths, all signed two's complement
   localparam int T_W    = FRAC_BITS + 2;           // fraction, offsets, fade out
   localparam int K_W    = FRAC_BITS + 6;           // 6t-15 and fade inner term
   localparam int G_W    = FRAC_BITS + 4;           // corner dot products
   localparam int D_W    = FRAC_BITS + 5;           // gradient differences
   localparam int L_W    = D_W;                     // lerp along x
   localparam int DL_W   = L_W + 1;                 // difference of the two rows
   localparam int R_W    = DL_W;                    // final sum before saturation
   localparam int PA_W   = T_W + K_W;
   localparam int PB_W   = 2 * T_W;
   localparam int PC_W   = 2 * T_W;
   localparam int PD_W   = T_W + K_W;
   localparam int PL_W   = T_W + D_W;
   localparam int PR_W   = T_W + DL_W;
   localparam int PROD_W = T_W + K_W + 2;           // covers every product
   localparam int RND_W  = PROD_W - FRAC_BITS;

   // Pipeline shape
   localparam int LANES      = 2;
   localparam int LANE_X     = 0;
   localparam int LANE_Y     = 1;
   localparam int CORNERS    = 4;
   localparam int PIPE_DEPTH = 9;

   // Corner slots: (x,y), (x+1,y), (x,y+1), (x+1,y+1)
   localparam int C00 = 0;
   localparam int C10 = 1;
   localparam int C01 = 2;
   localparam int C11 = 3;

   localparam logic signed [T_W-1:0]    ONE_T    = T_W'(1) <<< FRAC_BITS;
   localparam logic signed [K_W-1:0]    K_FADE_B = K_W'(FADE_B) <<< FRAC_BITS;
   localparam logic signed [K_W-1:0]    K_FADE_C = K_W'(FADE_C) <<< FRAC_BITS;
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [R_W-1:0]    SAT_HI   = R_W'(OUT_LIMIT);
   localparam logic signed [R_W-1:0]    SAT_LO   = -SAT_HI;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_EVAL = 1'b1
   } func_type;

   // Signed product of a fraction-width operand and a wide operand,
   // sign-extended to the common product width
   function automatic logic signed [PROD_W-1:0] smul(input logic signed [T_W-1:0] a,
                                                     input logic signed [K_W-1:0] b);
      logic signed [T_W+K_W-1:0] p;
      p = a * b;
      return PROD_W'(p);
   endfunction

   // floor(p / 2^F + 1/2): add half, then arithmetic shift by a part-select
   function automatic logic signed [RND_W-1:0] qround(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      q = p + RND_HALF;
      return $signed(q[PROD_W-1:FRAC_BITS]);
   endfunction

   // Diagonal gradient: bit0 picks sign of dx, bit1 picks sign of dy
   function automatic logic signed [G_W-1:0] grad(input logic [1:0]           h,
                                                  input logic signed [T_W-1:0] dx,
                                                  input logic signed [T_W-1:0] dy);
      logic signed [G_W-1:0] a;
      logic signed [G_W-1:0] b;
      a = h[0] ? G_W'(dx) : -G_W'(dx);
      b = h[1] ? G_W'(dy) : -G_W'(dy);
      return a + b;
   endfunction

endpackage

### hdl/perlin_noise_2d_core.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d_core
// Pipelined 2D improved gradient noise at a Q16.16 point, Q2.16 result.
// ----------------------------------------------------------------------------
// Usage:
//  - Input transfer: start high while busy is low. req_func selects a table
//    load (req_entry_index/req_entry_value) or a noise evaluation at
//    (req_x_position, req_y_position).
//  - All 256 table entries must be loaded before the first evaluation.
//    Loads flow down the pipeline in order with evaluations, so a reload
//    between evaluations affects only later items.
//  - An evaluation gives one result: rsp_valid comes from the last valid
//    register, is high for exactly one cycle with rsp_noise_value, and the
//    result is taken in that cycle. Loads give no result.
//  - Throughput: one item per cycle. Nine register stages; the table lookup
//    uses three copies of the table (one for the row hashes, two for the
//    corner hashes) so six reads fit in one item slot.
//  - The receiver cannot stall; results are always taken.
//  - Reset (synchronous) clears the pipeline valid bits; busy is high while
//    reset is asserted. The table contents are kept and stay undefined until
//    written.
// ----------------------------------------------------------------------------
module perlin_noise_2d_core
   import pn2d_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_func,
   input  logic signed [COORD_W-1:0]  req_x_position,
   input  logic signed [COORD_W-1:0]  req_y_position,
   input  logic [ENTRY_W-1:0]         req_entry_index,
   input  logic [ENTRY_W-1:0]         req_entry_value,
   output logic                       rsp_valid,
   output logic signed [OUT_W-1:0]    rsp_noise_value
);

   // Table copies
   logic [ENTRY_W-1:0] perm_a  [TABLE_SIZE];
   logic [ENTRY_W-1:0] perm_b0 [TABLE_SIZE];
   logic [ENTRY_W-1:0] perm_b1 [TABLE_SIZE];

   logic                   accept;
   logic [TABLE_BITS-1:0]  cx_in;
   logic [TABLE_BITS-1:0]  cy_in;
   logic [TABLE_BITS-1:0]  cy1_in;
   logic [PIPE_DEPTH-1:0]  vld_in;
   logic [PIPE_DEPTH-1:0]  vld_ff;
   logic                   s0_load_ff;

   // Stage 0: cell, fraction, row hashes
   logic [TABLE_BITS-1:0]  s0_cx_ff;
   logic [FRAC_BITS-1:0]   s0_frac_ff [LANES];
   logic [TABLE_BITS-1:0]  s0_index_ff;
   logic [ENTRY_W-1:0]     s0_value_ff;
   logic [ENTRY_W-1:0]     s0_py0_ff;
   logic [ENTRY_W-1:0]     s0_py1_ff;

   // Stage 1: corner hashes, first fade products
   logic [TABLE_BITS-1:0]  a00;
   logic [TABLE_BITS-1:0]  a10;
   logic [TABLE_BITS-1:0]  a01;
   logic [TABLE_BITS-1:0]  a11;
   logic [ENTRY_W-1:0]     h_ff [CORNERS];
   logic [FRAC_BITS-1:0]   s1_frac_ff [LANES];
   logic signed [T_W-1:0]  t0 [LANES];
   logic signed [K_W-1:0]  k0 [LANES];
   logic signed [PA_W-1:0] pa_in [LANES];
   logic signed [PA_W-1:0] pa_ff [LANES];
   logic signed [PB_W-1:0] pb_in [LANES];
   logic signed [PB_W-1:0] pb_ff [LANES];

   // Stage 2: dot products, fade inner term, t^3 product
   logic signed [T_W-1:0]  t1 [LANES];
   logic signed [T_W-1:0]  t2 [LANES];
   logic signed [T_W-1:0]  off1 [LANES];
   logic signed [G_W-1:0]  g_in [CORNERS];
   logic signed [G_W-1:0]  g_ff [CORNERS];
   logic signed [K_W-1:0]  inner_in [LANES];
   logic signed [K_W-1:0]  inner_ff [LANES];
   logic signed [PC_W-1:0] pc_in [LANES];
   logic signed [PC_W-1:0] pc_ff [LANES];

   // Stage 3: fade product, gradient differences per row
   logic signed [T_W-1:0]  t3 [LANES];
   logic signed [PD_W-1:0] pd_in [LANES];
   logic signed [PD_W-1:0] pd_ff [LANES];
   logic signed [G_W-1:0]  s3_g_ff [LANES];
   logic signed [D_W-1:0]  s3_d_in [LANES];
   logic signed [D_W-1:0]  s3_d_ff [LANES];

   // Stage 4: fade results
   logic signed [T_W-1:0]  u_in [LANES];
   logic signed [T_W-1:0]  u_ff [LANES];
   logic signed [G_W-1:0]  s4_g_ff [LANES];
   logic signed [D_W-1:0]  s4_d_ff [LANES];

   // Stage 5: lerp products along x
   logic signed [PL_W-1:0] pl_in [LANES];
   logic signed [PL_W-1:0] pl_ff [LANES];
   logic signed [G_W-1:0]  s5_g_ff [LANES];
   logic signed [T_W-1:0]  s5_v_ff;

   // Stage 6: row values
   logic signed [L_W-1:0]  l_in [LANES];
   logic signed [L_W-1:0]  l_ff [LANES];
   logic signed [T_W-1:0]  s6_v_ff;

   // Stage 7: lerp product along y
   logic signed [PR_W-1:0] pr_in;
   logic signed [PR_W-1:0] pr_ff;
   logic signed [L_W-1:0]  s7_l0_ff;

   // Stage 8: result
   logic signed [R_W-1:0]  r_sum;
   logic signed [R_W-1:0]  r_sat;
   logic signed [OUT_W-1:0] rsp_noise_value_ff;

   // No back-pressure: only reset holds off input transfers
   assign busy   = reset;
   assign accept = start && !busy;

   // Cell coordinates modulo the table size
   assign cx_in  = req_x_position[FRAC_BITS +: TABLE_BITS];
   assign cy_in  = req_y_position[FRAC_BITS +: TABLE_BITS];
   assign cy1_in = cy_in + TABLE_BITS'(1);

   // Valid bits of evaluations travel with the data
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], accept && (req_func == FUNC_EVAL)};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         s0_load_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         s0_load_ff <= accept && (req_func == FUNC_LOAD);
      end
   end

   // Row-hash copy: written at transfer, read at cy and cy+1
   always_ff @(posedge clock) begin
      if (accept && (req_func == FUNC_LOAD)) begin
         perm_a[req_entry_index[TABLE_BITS-1:0]] <= req_entry_value;
      end
      s0_py0_ff <= perm_a[cy_in];
      s0_py1_ff <= perm_a[cy1_in];
   end

   // Corner-hash addresses
   always_comb begin
      a00 = s0_cx_ff + s0_py0_ff;
      a10 = s0_cx_ff + TABLE_BITS'(1) + s0_py0_ff;
      a01 = s0_cx_ff + s0_py1_ff;
      a11 = s0_cx_ff + TABLE_BITS'(1) + s0_py1_ff;
   end

   // Corner-hash copies: a load is written one stage later, in order
   // with the evaluations that read them
   always_ff @(posedge clock) begin
      if (s0_load_ff) begin
         perm_b0[s0_index_ff] <= s0_value_ff;
         perm_b1[s0_index_ff] <= s0_value_ff;
      end
      h_ff[C00] <= perm_b0[a00];
      h_ff[C10] <= perm_b0[a10];
      h_ff[C01] <= perm_b1[a01];
      h_ff[C11] <= perm_b1[a11];
   end

   // Fade, gradients and interpolation datapath
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         // t*(6t-15) and t*t
         t0[i]    = $signed(T_W'(s0_frac_ff[i]));
         k0[i]    = K_W'(t0[i]) * K_W'(FADE_A) - K_FADE_B;
         pa_in[i] = PA_W'(smul(t0[i], k0[i]));
         pb_in[i] = PB_W'(smul(t0[i], K_W'(t0[i])));
         // inner term and t^3
         t1[i]       = $signed(T_W'(s1_frac_ff[i]));
         off1[i]     = t1[i] - ONE_T;
         inner_in[i] = K_W'(qround(PROD_W'(pa_ff[i]))) + K_FADE_C;
         t2[i]       = T_W'(qround(PROD_W'(pb_ff[i])));
         pc_in[i]    = PC_W'(smul(t2[i], K_W'(t1[i])));
         // t^3 * inner
         t3[i]    = T_W'(qround(PROD_W'(pc_ff[i])));
         pd_in[i] = PD_W'(smul(t3[i], inner_ff[i]));
         u_in[i]  = T_W'(qround(PROD_W'(pd_ff[i])));
      end

      // Corner (i,j) takes offset (fx-i, fy-j)
      g_in[C00] = grad(h_ff[C00][1:0], t1[LANE_X],   t1[LANE_Y]);
      g_in[C10] = grad(h_ff[C10][1:0], off1[LANE_X], t1[LANE_Y]);
      g_in[C01] = grad(h_ff[C01][1:0], t1[LANE_X],   off1[LANE_Y]);
      g_in[C11] = grad(h_ff[C11][1:0], off1[LANE_X], off1[LANE_Y]);

      // Row differences: row 0 at y, row 1 at y+1
      s3_d_in[0] = D_W'(g_ff[C10]) - D_W'(g_ff[C00]);
      s3_d_in[1] = D_W'(g_ff[C11]) - D_W'(g_ff[C01]);

      // Lerp along x with u, then along y with v
      for (int j = 0; j < LANES; j++) begin
         pl_in[j] = PL_W'(smul(u_ff[LANE_X], K_W'(s4_d_ff[j])));
         l_in[j]  = L_W'(s5_g_ff[j]) + L_W'(qround(PROD_W'(pl_ff[j])));
      end
      pr_in = PR_W'(smul(s6_v_ff, K_W'(DL_W'(l_ff[1]) - DL_W'(l_ff[0]))));

      // Final sum and saturation to the Q2.16 range
      r_sum = R_W'(s7_l0_ff) + R_W'(qround(PROD_W'(pr_ff)));
      if (r_sum > SAT_HI) begin
         r_sat = SAT_HI;
      end else if (r_sum < SAT_LO) begin
         r_sat = SAT_LO;
      end else begin
         r_sat = r_sum;
      end
   end

   // Pipeline payload registers
   always_ff @(posedge clock) begin
      // stage 0
      s0_cx_ff           <= cx_in;
      s0_frac_ff[LANE_X] <= req_x_position[FRAC_BITS-1:0];
      s0_frac_ff[LANE_Y] <= req_y_position[FRAC_BITS-1:0];
      s0_index_ff        <= req_entry_index[TABLE_BITS-1:0];
      s0_value_ff        <= req_entry_value;
      for (int i = 0; i < LANES; i++) begin
         // stage 1
         s1_frac_ff[i] <= s0_frac_ff[i];
         pa_ff[i]      <= pa_in[i];
         pb_ff[i]      <= pb_in[i];
         // stage 2
         inner_ff[i]   <= inner_in[i];
         pc_ff[i]      <= pc_in[i];
         // stage 3
         pd_ff[i]      <= pd_in[i];
         s3_d_ff[i]    <= s3_d_in[i];
         // stage 4
         u_ff[i]       <= u_in[i];
         s4_g_ff[i]    <= s3_g_ff[i];
         s4_d_ff[i]    <= s3_d_ff[i];
         // stage 5
         pl_ff[i]      <= pl_in[i];
         s5_g_ff[i]    <= s4_g_ff[i];
         // stage 6
         l_ff[i]       <= l_in[i];
      end
      for (int c = 0; c < CORNERS; c++) begin
         g_ff[c] <= g_in[c];
      end
      s3_g_ff[0]         <= g_ff[C00];
      s3_g_ff[1]         <= g_ff[C01];
      s5_v_ff            <= u_ff[LANE_Y];
      s6_v_ff            <= s5_v_ff;
      // stage 7
      pr_ff              <= pr_in;
      s7_l0_ff           <= l_ff[0];
      // stage 8
      rsp_noise_value_ff <= r_sat[OUT_W-1:0];
   end

   assign rsp_valid       = vld_ff[PIPE_DEPTH-1];
   assign rsp_noise_value = rsp_noise_value_ff;

endmodule

### hdl/pn2d_checker.sv
// ----------------------------------------------------------------------------
// pn2d_port_props
// Port-level checks of the noise core: fixed latency, no result for loads, result range.
// ----------------------------------------------------------------------------
module pn2d_port_props
   import pn2d_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    req_func,
   input logic                    rsp_valid,
   input logic signed [OUT_W-1:0] rsp_noise_value
);

   // An evaluation transfer yields its result a fixed number of edges later
   property p_eval_gives_result;
      @(posedge clock) disable iff (reset)
         (start && !busy && (req_func == FUNC_EVAL)) |-> ##(PIPE_DEPTH) rsp_valid;
   endproperty
   a_eval_gives_result : assert property (p_eval_gives_result)
      else $error("evaluation transfer without result");

   // A load transfer never yields a result
   property p_load_silent;
      @(posedge clock) disable iff (reset)
         (start && !busy && (req_func == FUNC_LOAD)) |-> ##(PIPE_DEPTH) !rsp_valid;
   endproperty
   a_load_silent : assert property (p_load_silent)
      else $error("result produced for a table load");

   // Every result traces back to an evaluation transfer
   property p_result_has_source;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> $past(start && !busy && (req_func == FUNC_EVAL), PIPE_DEPTH);
   endproperty
   a_result_has_source : assert property (p_result_has_source)
      else $error("result without matching evaluation");

   // Results stay within the saturated Q2.16 range
   property p_result_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_noise_value <= OUT_W'(OUT_LIMIT)) &&
                       (rsp_noise_value >= -OUT_W'(OUT_LIMIT));
   endproperty
   a_result_range : assert property (p_result_range)
      else $error("noise value out of range");

endmodule

bind perlin_noise_2d_core pn2d_port_props u_pn2d_port_props (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_func        (req_func),
   .rsp_valid       (rsp_valid),
   .rsp_noise_value (rsp_noise_value)
);

### dv/pn2d_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pn2d_checker
// Watches both transfers of the 2D gradient noise core, keeps its own copy of
// the permutation table, computes the expected noise for every accepted
// evaluation and compares each result strobe against the oldest one due.
// ----------------------------------------------------------------------------
module pn2d_checker
   import pn2d_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic                     req_func,
   input  logic signed [COORD_W-1:0] req_x_position,
   input  logic signed [COORD_W-1:0] req_y_position,
   input  logic [ENTRY_W-1:0]       req_entry_index,
   input  logic [ENTRY_W-1:0]       req_entry_value,
   input  logic                     rsp_valid,
   input  logic signed [OUT_W-1:0]  rsp_noise_value,
   output int                       fail_count,
   output int                       due_count
);

   localparam int REPORT_MAX = 10;

   typedef struct {
      logic signed [COORD_W-1:0] x_pos;
      logic signed [COORD_W-1:0] y_pos;
      logic signed [OUT_W-1:0]   noise;
   } noise_due_type;

   logic [ENTRY_W-1:0] perm_copy [TABLE_SIZE];
   noise_due_type      noise_due [$];

   // Q.F product, rounded half toward +inf
   function automatic longint fix_mul(input longint a, input longint b);
      return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // 6t^5 - 15t^4 + 10t^3, evaluated as t^3 * (t*(6t-15) + 10)
   function automatic longint fade_of(input longint t);
      longint one;
      longint inner;
      longint t3;
      one   = longint'(1) <<< FRAC_BITS;
      inner = fix_mul(t, FADE_A * t - FADE_B * one) + FADE_C * one;
      t3    = fix_mul(fix_mul(t, t), t);
      return fix_mul(t3, inner);
   endfunction

   // Dot product of a diagonal gradient with the corner offset
   function automatic longint corner_dot(input logic [1:0] h, input longint dx,
                                         input longint dy);
      return (h[0] ? dx : -dx) + (h[1] ? dy : -dy);
   endfunction

   // Expected noise at a Q16.16 point from the table copy
   function automatic logic signed [OUT_W-1:0] noise_at(input logic [COORD_W-1:0] xp,
                                                         input logic [COORD_W-1:0] yp);
      logic [TABLE_BITS-1:0] cx0, cx1, cy0, cy1;
      logic [TABLE_BITS-1:0] row0, row1;
      logic [TABLE_BITS-1:0] i00, i10, i01, i11;
      longint one, fx, fy, u, v;
      longint g00, g10, g01, g11, l0, l1, r;
      one  = longint'(1) <<< FRAC_BITS;
      fx   = longint'({1'b0, xp[FRAC_BITS-1:0]});
      fy   = longint'({1'b0, yp[FRAC_BITS-1:0]});
      // integer cell modulo the table size is a plain bit slice
      cx0  = xp[FRAC_BITS +: TABLE_BITS];
      cy0  = yp[FRAC_BITS +: TABLE_BITS];
      cx1  = cx0 + 1'b1;
      cy1  = cy0 + 1'b1;
      row0 = perm_copy[cy0];
      row1 = perm_copy[cy1];
      i00  = cx0 + row0;
      i10  = cx1 + row0;
      i01  = cx0 + row1;
      i11  = cx1 + row1;
      g00  = corner_dot(perm_copy[i00][1:0], fx, fy);
      g10  = corner_dot(perm_copy[i10][1:0], fx - one, fy);
      g01  = corner_dot(perm_copy[i01][1:0], fx, fy - one);
      g11  = corner_dot(perm_copy[i11][1:0], fx - one, fy - one);
      u    = fade_of(fx);
      v    = fade_of(fy);
      l0   = g00 + fix_mul(u, g10 - g00);
      l1   = g01 + fix_mul(u, g11 - g01);
      r    = l0 + fix_mul(v, l1 - l0);
      // internal fraction already matches the Q2.16 output
      if (r > OUT_LIMIT) r = OUT_LIMIT;
      if (r < -OUT_LIMIT) r = -OUT_LIMIT;
      return r[OUT_W-1:0];
   endfunction

   // Predict on input transfers, compare on result strobes
   always @(posedge clock) begin
      noise_due_type item;
      if (!reset) begin
         if (rsp_valid) begin
            if (noise_due.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("%0t: unexpected result noise=%0d", $realtime, rsp_noise_value);
               fail_count = fail_count + 1;
            end else begin
               item = noise_due.pop_front();
               if (rsp_noise_value !== item.noise) begin
                  if (fail_count < REPORT_MAX)
                     $display("%0t: noise mismatch at x=%h y=%h expected %0d actual %0d",
                              $realtime, item.x_pos, item.y_pos, item.noise,
                              rsp_noise_value);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            if (req_func == FUNC_EVAL) begin
               item.x_pos = req_x_position;
               item.y_pos = req_y_position;
               item.noise = noise_at(req_x_position, req_y_position);
               noise_due.push_back(item);
            end else begin
               perm_copy[req_entry_index[TABLE_BITS-1:0]] = req_entry_value;
            end
         end
         due_count = noise_due.size();
      end
   end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the 2D gradient noise core: loads a shuffled
// permutation table, runs directed corner points and reloads, then a long
// random mix of evaluations and loads sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb;
   import pn2d_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 2 * PIPE_DEPTH + 4;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_func;
   logic signed [COORD_W-1:0] req_x_position;
   logic signed [COORD_W-1:0] req_y_position;
   logic [ENTRY_W-1:0]        req_entry_index;
   logic [ENTRY_W-1:0]        req_entry_value;
   logic                      rsp_valid;
   logic signed [OUT_W-1:0]   rsp_noise_value;
   int                        fail_count;
   int                        due_count;
   int                        cycle_count;
   int                        burst_left;

   perlin_noise_2d_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_x_position  (req_x_position),
      .req_y_position  (req_y_position),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value)
   );

   pn2d_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_x_position  (req_x_position),
      .req_y_position  (req_y_position),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .fail_count      (fail_count),
      .due_count       (due_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // One transfer; bursts end in a random gap with start low, which may be empty
   task automatic send_item(input func_type f, input logic [COORD_W-1:0] xp,
                            input logic [COORD_W-1:0] yp, input logic [ENTRY_W-1:0] idx,
                            input logic [ENTRY_W-1:0] val);
      int gap;
      req_func        <= f;
      req_x_position  <= xp;
      req_y_position  <= yp;
      req_entry_index <= idx;
      req_entry_value <= val;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
         gap        = $urandom_range(0, 12);
         burst_left = ($urandom_range(0, 9) < 2) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 8);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Random coordinate, biased toward fraction and cell edges
   function automatic logic [COORD_W-1:0] pick_coord();
      logic [15:0] edge_frac [4];
      logic [31:0] raw;
      edge_frac[0] = 16'h0000;
      edge_frac[1] = 16'hFFFF;
      edge_frac[2] = 16'h8000;
      edge_frac[3] = 16'h0001;
      raw = $urandom;
      case ($urandom_range(0, 4))
         0: pick_coord = raw;
         1: pick_coord = {raw[31:16], edge_frac[$urandom_range(0, 3)]};
         2: pick_coord = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
         3: pick_coord = {raw[31:16], 16'h8000 + 16'($urandom_range(0, 7)) - 16'd4};
         default: pick_coord = {raw[31:24], ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                                raw[15:0]};
      endcase
   endfunction

   // Main stimulus
   initial begin
      logic [ENTRY_W-1:0] perm [TABLE_SIZE];
      logic [ENTRY_W-1:0] swap;
      logic [COORD_W-1:0] dir_x [14];
      logic [COORD_W-1:0] dir_y [14];
      int                 j;

      reset           <= 1'b1;
      start           <= 1'b0;
      req_func        <= FUNC_LOAD;
      req_x_position  <= '0;
      req_y_position  <= '0;
      req_entry_index <= '0;
      req_entry_value <= '0;
      burst_left      = 4;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Shuffled permutation, loaded entry by entry
      for (int i = 0; i < TABLE_SIZE; i++) perm[i] = ENTRY_W'(i);
      for (int i = TABLE_SIZE - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         swap    = perm[i];
         perm[i] = perm[j];
         perm[j] = swap;
      end
      for (int i = 0; i < TABLE_SIZE; i++)
         send_item(FUNC_LOAD, $urandom, $urandom, ENTRY_W'(i), perm[i]);

      // Directed points: origin, coordinate extremes, fraction edges, cell wrap
      dir_x[0]  = 32'h0000_0000;  dir_y[0]  = 32'h0000_0000;
      dir_x[1]  = 32'h7FFF_FFFF;  dir_y[1]  = 32'h7FFF_FFFF;
      dir_x[2]  = 32'h8000_0000;  dir_y[2]  = 32'h8000_0000;
      dir_x[3]  = 32'h7FFF_FFFF;  dir_y[3]  = 32'h8000_0000;
      dir_x[4]  = 32'h8000_0000;  dir_y[4]  = 32'h7FFF_FFFF;
      dir_x[5]  = 32'h0000_FFFF;  dir_y[5]  = 32'h0000_FFFF;
      dir_x[6]  = 32'h0000_8000;  dir_y[6]  = 32'h0000_8000;
      dir_x[7]  = 32'h00FF_FFFF;  dir_y[7]  = 32'h00FF_FFFF;
      dir_x[8]  = 32'hFFFF_FFFF;  dir_y[8]  = 32'hFFFF_FFFF;
      dir_x[9]  = 32'h0001_0000;  dir_y[9]  = 32'hFFFF_0000;
      dir_x[10] = 32'h00FF_0000;  dir_y[10] = 32'h0000_0001;
      dir_x[11] = 32'h0000_4000;  dir_y[11] = 32'h0000_C000;
      dir_x[12] = 32'hFFFF_8000;  dir_y[12] = 32'h0000_8000;
      dir_x[13] = 32'h1234_5678;  dir_y[13] = 32'hFEDC_BA98;
      for (int i = 0; i < 14; i++)
         send_item(FUNC_EVAL, dir_x[i], dir_y[i], ENTRY_W'($urandom), ENTRY_W'($urandom));

      // Reload between evaluations: extreme slots and values
      send_item(FUNC_LOAD, '0, '0, 8'h00, 8'hFF);
      send_item(FUNC_LOAD, '0, '0, 8'hFF, 8'h00);
      send_item(FUNC_EVAL, 32'h0000_0000, 32'h0000_0000, '0, '0);
      send_item(FUNC_EVAL, 32'h00FF_8000, 32'h00FF_8000, '0, '0);
      send_item(FUNC_LOAD, '0, '0, 8'h80, 8'h7F);
      send_item(FUNC_EVAL, 32'h007F_C000, 32'h0080_4000, '0, '0);

      // Random mix: mostly evaluations, some table rewrites
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 15)
            send_item(FUNC_LOAD, $urandom, $urandom, ENTRY_W'($urandom),
                      ENTRY_W'($urandom));
         else
            send_item(FUNC_EVAL, pick_coord(), pick_coord(), ENTRY_W'($urandom),
                      ENTRY_W'($urandom));
      end
      if (start) start <= 1'b0;

      // Drain, then let any stray result show up
      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && due_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
